// File: rtl/tfn_pkg.sv
// Package for the triangle face normal pipeline.
// Holds the output width and the control record that travels with each item.
// No dependencies.
package tfn_pkg;

	// Width of each normal component on the result ports.
	localparam int OUT_BITS = 32;

	// Control that rides along with an item once the cross product is known.
	typedef struct packed {
		logic       vld;
		logic       degen;
		logic [2:0] neg;
	} tfn_ctrl_t;

endpackage

// File: rtl/tfn_cross.sv
// Front end of the face normal pipeline: edge vectors, products, cross product.
// Three register stages; emits component magnitudes and signs.
// Depends on tfn_pkg.
module tfn_cross #(
	parameter int CB = 24,
	parameter int MW = 2 * CB + 3
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    vld,
	input  logic [8:0][CB-1:0]      v,
	output logic [2:0][MW-1:0]      mag,
	output tfn_pkg::tfn_ctrl_t      ctrl
);
	import tfn_pkg::*;

	localparam int DW = CB + 1;
	localparam int PW = 2 * DW;

	logic [2:0][DW-1:0] a_s1, b_s1;
	logic [2:0][PW-1:0] m1_s2, m2_s2;
	logic [2:0][MW-1:0] mag_s3;
	logic               vld_s1, vld_s2;
	tfn_ctrl_t          ctrl_s3;
	logic [2:0][MW-1:0] cv;
	logic [2:0][MW-1:0] cmag;
	logic [2:0]         cneg;

	// Valid bits of the first two stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= vld;
			vld_s2 <= vld_s1;
		end
	end

	// Stage 1: edge vectors a = p0 - p1 and b = p1 - p2.
	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			a_s1[k] <= $signed({v[k][CB-1], v[k]}) - $signed({v[k+3][CB-1], v[k+3]});
			b_s1[k] <= $signed({v[k+3][CB-1], v[k+3]}) - $signed({v[k+6][CB-1], v[k+6]});
		end
	end

	// Stage 2: the six signed products of the cross product.
	always_ff @(posedge clk) begin
		m1_s2[0] <= PW'($signed(a_s1[1]) * $signed(b_s1[2]));
		m2_s2[0] <= PW'($signed(a_s1[2]) * $signed(b_s1[1]));
		m1_s2[1] <= PW'($signed(a_s1[2]) * $signed(b_s1[0]));
		m2_s2[1] <= PW'($signed(a_s1[0]) * $signed(b_s1[2]));
		m1_s2[2] <= PW'($signed(a_s1[0]) * $signed(b_s1[1]));
		m2_s2[2] <= PW'($signed(a_s1[1]) * $signed(b_s1[0]));
	end

	// Cross product components, split into sign and magnitude.
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			cv[k]   = MW'($signed(m1_s2[k])) - MW'($signed(m2_s2[k]));
			cneg[k] = cv[k][MW-1];
			cmag[k] = cneg[k] ? (~cv[k] + MW'(1)) : cv[k];
		end
	end

	// Stage 3 control: valid, degenerate flag and signs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s3 <= '0;
		end else begin
			ctrl_s3.vld   <= vld_s2;
			ctrl_s3.degen <= (cv == '0);
			ctrl_s3.neg   <= cneg;
		end
	end

	// Stage 3 payload.
	always_ff @(posedge clk) begin
		mag_s3 <= cmag;
	end

	assign mag  = mag_s3;
	assign ctrl = ctrl_s3;

endmodule

// File: rtl/tfn_square.sv
// Squares of the cross product magnitudes and their sum, in three stages.
// Each square is built from half-width partial products.
// Depends on tfn_pkg.
module tfn_square #(
	parameter int MW = 51
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [2:0][MW-1:0]       mag,
	input  tfn_pkg::tfn_ctrl_t       ctrl_in,
	output logic [2:0][2*MW-1:0]     sq,
	output logic [2*MW+1:0]          s,
	output tfn_pkg::tfn_ctrl_t       ctrl
);
	import tfn_pkg::*;

	localparam int HL  = MW / 2;
	localparam int HH  = MW - HL;
	localparam int SQW = 2 * MW;
	localparam int SW  = SQW + 2;

	logic [2:0][2*HH-1:0]  hh_s4;
	logic [2:0][HH+HL-1:0] hl_s4;
	logic [2:0][2*HL-1:0]  ll_s4;
	logic [2:0][SQW-1:0]   sq_s5, sq_s6;
	logic [SW-1:0]         s_s6;
	tfn_ctrl_t             ctrl_s4, ctrl_s5, ctrl_s6;

	// Control travels alongside the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s4 <= '0;
			ctrl_s5 <= '0;
			ctrl_s6 <= '0;
		end else begin
			ctrl_s4 <= ctrl_in;
			ctrl_s5 <= ctrl_s4;
			ctrl_s6 <= ctrl_s5;
		end
	end

	// Stage 4: partial products of the high and low halves.
	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			hh_s4[k] <= (2*HH)'(mag[k][MW-1:HL]) * (2*HH)'(mag[k][MW-1:HL]);
			hl_s4[k] <= (HH+HL)'(mag[k][MW-1:HL]) * (HH+HL)'(mag[k][HL-1:0]);
			ll_s4[k] <= (2*HL)'(mag[k][HL-1:0]) * (2*HL)'(mag[k][HL-1:0]);
		end
	end

	// Stage 5: assemble each square.
	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			sq_s5[k] <= (SQW'(hh_s4[k]) << (2 * HL)) + (SQW'(hl_s4[k]) << (HL + 1))
				+ SQW'(ll_s4[k]);
		end
	end

	// Stage 6: squared length of the cross product.
	always_ff @(posedge clk) begin
		sq_s6 <= sq_s5;
		s_s6  <= SW'(sq_s5[0]) + SW'(sq_s5[1]) + SW'(sq_s5[2]);
	end

	assign sq   = sq_s6;
	assign s    = s_s6;
	assign ctrl = ctrl_s6;

endmodule

// File: rtl/tfn_div_stage.sv
// One bit of the normalizing quotient for all three components.
// Keeps remainder r = c^2 * 2^(2F) - q^2 * S and partial p = q * S exact.
// Depends on tfn_pkg.
module tfn_div_stage #(
	parameter int SW  = 104,
	parameter int QB  = 31,
	parameter int W   = 166,
	parameter int BIT = 0
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  tfn_pkg::tfn_ctrl_t      ctrl_in,
	input  logic [SW-1:0]           s_in,
	input  logic [2:0][W-1:0]       r_in,
	input  logic [2:0][SW+QB-1:0]   p_in,
	input  logic [2:0][QB-1:0]      q_in,
	output tfn_pkg::tfn_ctrl_t      ctrl,
	output logic [SW-1:0]           s,
	output logic [2:0][W-1:0]       r,
	output logic [2:0][SW+QB-1:0]   p,
	output logic [2:0][QB-1:0]      q
);
	import tfn_pkg::*;

	localparam int PWD = SW + QB;

	tfn_ctrl_t            ctrl_s1;
	logic [SW-1:0]        s_s1;
	logic [2:0][W-1:0]    r_s1;
	logic [2:0][PWD-1:0]  p_s1;
	logic [2:0][QB-1:0]   q_s1;
	logic [2:0][W-1:0]    trial;
	logic [2:0]           take;

	// Growth of q^2 * S when this bit is set: 2^(BIT+1) * q * S + 2^(2*BIT) * S.
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			trial[k] = (W'(p_in[k]) << (BIT + 1)) + (W'(s_in) << (2 * BIT));
			take[k]  = (trial[k] <= r_in[k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
		end else begin
			ctrl_s1 <= ctrl_in;
		end
	end

	// Accept the bit where the remainder stays non-negative.
	always_ff @(posedge clk) begin
		s_s1 <= s_in;
		for (int k = 0; k < 3; k++) begin
			if (take[k]) begin
				r_s1[k] <= r_in[k] - trial[k];
				p_s1[k] <= p_in[k] + (PWD'(s_in) << BIT);
				q_s1[k] <= q_in[k] | (QB'(1) << BIT);
			end else begin
				r_s1[k] <= r_in[k];
				p_s1[k] <= p_in[k];
				q_s1[k] <= q_in[k];
			end
		end
	end

	assign ctrl = ctrl_s1;
	assign s    = s_s1;
	assign r    = r_s1;
	assign p    = p_s1;
	assign q    = q_s1;

endmodule

// File: rtl/triangle_face_normal.sv
// Unit face normal of a triangle, one item per clock.
// Depends on tfn_pkg, tfn_cross, tfn_square and tfn_div_stage.
//
// An item is the three vertices p0, p1, p2 as signed coordinates; it is taken at
// each rising edge where start is high and busy is low. busy is always low, so
// an item may enter every cycle. The block forms the cross product of
// (p0 - p1) and (p1 - p2) and divides each component by the exact length,
// giving signed Q1.30 values truncated toward zero.
// The pipeline has six stages for the edge vectors, cross product and squared
// length, one stage per quotient bit, and an output register. Throughput is
// one item per cycle.
// Each result appears for one cycle with done high; the receiver cannot stall.
// A zero cross product gives a zero normal with degenerate set.
// Reset clears every valid bit, so no result appears until new items arrive.
module triangle_face_normal #(
	parameter int COORD_BITS       = 24,
	parameter int NORMAL_FRAC_BITS = 30
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic signed [COORD_BITS-1:0]         p0_x,
	input  logic signed [COORD_BITS-1:0]         p0_y,
	input  logic signed [COORD_BITS-1:0]         p0_z,
	input  logic signed [COORD_BITS-1:0]         p1_x,
	input  logic signed [COORD_BITS-1:0]         p1_y,
	input  logic signed [COORD_BITS-1:0]         p1_z,
	input  logic signed [COORD_BITS-1:0]         p2_x,
	input  logic signed [COORD_BITS-1:0]         p2_y,
	input  logic signed [COORD_BITS-1:0]         p2_z,
	output logic                                 done,
	output logic signed [tfn_pkg::OUT_BITS-1:0]  normal_x,
	output logic signed [tfn_pkg::OUT_BITS-1:0]  normal_y,
	output logic signed [tfn_pkg::OUT_BITS-1:0]  normal_z,
	output logic                                 degenerate
);
	import tfn_pkg::*;

	localparam int F   = NORMAL_FRAC_BITS;
	localparam int MW  = 2 * COORD_BITS + 3;
	localparam int SQW = 2 * MW;
	localparam int SW  = SQW + 2;
	localparam int QB  = F + 1;
	localparam int PWD = SW + QB;
	localparam int W   = SQW + 2 * F + 4;
	localparam int LAT = F + 8;
	localparam logic signed [OUT_BITS-1:0] ONE = OUT_BITS'(1) << F;

	logic [8:0][COORD_BITS-1:0]     v;
	logic [2:0][MW-1:0]             mag;
	tfn_ctrl_t                      ctrl_cr, ctrl_sq;
	logic [2:0][SQW-1:0]            sq;
	logic [SW-1:0]                  s_sq;
	tfn_ctrl_t [F+1:0]              ctrl_pipe;
	logic [F+1:0][SW-1:0]           s_pipe;
	logic [F+1:0][2:0][W-1:0]       r_pipe;
	logic [F+1:0][2:0][PWD-1:0]     p_pipe;
	logic [F+1:0][2:0][QB-1:0]      q_pipe;
	logic [2:0][OUT_BITS-1:0]       nrm;
	logic                           done_q, degen_q;
	logic [2:0][OUT_BITS-1:0]       nrm_q;

	assign busy = 1'b0;
	assign v = {p2_z, p2_y, p2_x, p1_z, p1_y, p1_x, p0_z, p0_y, p0_x};

	// Edge vectors and cross product.
	tfn_cross #(.CB(COORD_BITS), .MW(MW)) u_cross (
		.clk    (clk),
		.arst_n (arst_n),
		.vld    (start & ~busy),
		.v      (v),
		.mag    (mag),
		.ctrl   (ctrl_cr)
	);

	// Squares and squared length.
	tfn_square #(.MW(MW)) u_square (
		.clk     (clk),
		.arst_n  (arst_n),
		.mag     (mag),
		.ctrl_in (ctrl_cr),
		.sq      (sq),
		.s       (s_sq),
		.ctrl    (ctrl_sq)
	);

	// Quotient recurrence starts with r = c^2 * 2^(2F), p = 0, q = 0.
	assign ctrl_pipe[0] = ctrl_sq;
	assign s_pipe[0]    = s_sq;
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			r_pipe[0][k] = W'(sq[k]) << (2 * F);
			p_pipe[0][k] = '0;
			q_pipe[0][k] = '0;
		end
	end

	// One stage per quotient bit, most significant first.
	for (genvar i = 0; i <= F; i++) begin : g_div
		tfn_div_stage #(.SW(SW), .QB(QB), .W(W), .BIT(F - i)) u_stage (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctrl_in (ctrl_pipe[i]),
			.s_in    (s_pipe[i]),
			.r_in    (r_pipe[i]),
			.p_in    (p_pipe[i]),
			.q_in    (q_pipe[i]),
			.ctrl    (ctrl_pipe[i+1]),
			.s       (s_pipe[i+1]),
			.r       (r_pipe[i+1]),
			.p       (p_pipe[i+1]),
			.q       (q_pipe[i+1])
		);
	end

	// Restore signs; a degenerate item gives zero.
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			if (ctrl_pipe[F+1].degen) begin
				nrm[k] = '0;
			end else if (ctrl_pipe[F+1].neg[k]) begin
				nrm[k] = ~OUT_BITS'(q_pipe[F+1][k]) + OUT_BITS'(1);
			end else begin
				nrm[k] = OUT_BITS'(q_pipe[F+1][k]);
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctrl_pipe[F+1].vld;
		end
	end

	always_ff @(posedge clk) begin
		nrm_q   <= nrm;
		degen_q <= ctrl_pipe[F+1].degen;
	end

	assign done       = done_q;
	assign normal_x   = nrm_q[0];
	assign normal_y   = nrm_q[1];
	assign normal_z   = nrm_q[2];
	assign degenerate = degen_q;

	// Every result must trace back to an item taken with start high.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LAT))
		else $error("result without a matching item");

	// A degenerate result carries a zero normal.
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && degenerate) |-> (normal_x == '0 && normal_y == '0 && normal_z == '0))
		else $error("degenerate result with nonzero normal");

	// Components never exceed one in magnitude.
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (normal_x <= ONE && normal_x >= -ONE && normal_y <= ONE
			&& normal_y >= -ONE && normal_z <= ONE && normal_z >= -ONE))
		else $error("normal component out of range");

endmodule

// File: tb/tb.sv
// Self-checking testbench for triangle_face_normal.
// Depends on tfn_pkg and the triangle_face_normal RTL; needs no files or arguments.
// A directed table is followed by random triangles, all checked against a local predictor.
module tb;
	import tfn_pkg::*;

	localparam int CB = 24;
	localparam int FB = 30;
	localparam int LATENCY = FB + 8;
	localparam int RANDOM_ITEMS = 1500;
	localparam logic signed [CB-1:0] CMAX = {1'b0, {(CB-1){1'b1}}};
	localparam logic signed [CB-1:0] CMIN = {1'b1, {(CB-1){1'b0}}};
	localparam logic signed [OUT_BITS-1:0] ONE = 1 <<< FB;

	typedef logic signed [CB-1:0] coord_t;
	typedef logic [191:0] wide_t;

	// Nine coordinates of one triangle: p0 xyz, p1 xyz, p2 xyz.
	typedef struct {
		coord_t v [9];
	} tri_t;

	typedef struct packed {
		logic signed [OUT_BITS-1:0] nx;
		logic signed [OUT_BITS-1:0] ny;
		logic signed [OUT_BITS-1:0] nz;
		logic                       degen;
	} normal_t;

	typedef struct {
		tri_t    t;
		bit      typed;
		normal_t res;
	} row_t;

	logic   clk;
	logic   arst_n;
	logic   start;
	logic   busy;
	coord_t p0_x, p0_y, p0_z, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z;
	logic   done;
	logic signed [OUT_BITS-1:0] normal_x, normal_y, normal_z;
	logic   degenerate;

	normal_t pending_normals [$];
	int      errors;
	row_t    table_rows [$];

	triangle_face_normal dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.p0_x(p0_x), .p0_y(p0_y), .p0_z(p0_z),
		.p1_x(p1_x), .p1_y(p1_y), .p1_z(p1_z),
		.p2_x(p2_x), .p2_y(p2_y), .p2_z(p2_z),
		.done(done), .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
		.degenerate(degenerate)
	);

	always #10 clk = ~clk;

	// Exact unit normal: cross product, then the largest q with q^2 * S <= c^2 * 2^(2F).
	function automatic normal_t unit_normal(tri_t t);
		logic signed [63:0] ax, ay, az, bx, by, bz;
		logic signed [63:0] c [3];
		logic [63:0]        mag;
		logic [63:0]        lo, hi, mid, q;
		wide_t              sq [3];
		wide_t              s, rhs, lhs;
		logic               neg [3];
		logic [31:0]        comp [3];
		normal_t            r;
		ax = 64'(t.v[0]) - 64'(t.v[3]);
		ay = 64'(t.v[1]) - 64'(t.v[4]);
		az = 64'(t.v[2]) - 64'(t.v[5]);
		bx = 64'(t.v[3]) - 64'(t.v[6]);
		by = 64'(t.v[4]) - 64'(t.v[7]);
		bz = 64'(t.v[5]) - 64'(t.v[8]);
		c[0] = ay * bz - az * by;
		c[1] = az * bx - ax * bz;
		c[2] = ax * by - ay * bx;
		s = '0;
		for (int k = 0; k < 3; k++) begin
			neg[k] = c[k] < 0;
			mag = neg[k] ? 64'(-c[k]) : 64'(c[k]);
			sq[k] = wide_t'(mag) * wide_t'(mag);
			s = s + sq[k];
		end
		if (s == '0) begin
			r.nx = '0;
			r.ny = '0;
			r.nz = '0;
			r.degen = 1'b1;
			return r;
		end
		for (int k = 0; k < 3; k++) begin
			rhs = sq[k] << (2 * FB);
			lo = 0;
			hi = 64'(1) << FB;
			while (lo < hi) begin
				mid = (lo + hi + 1) / 2;
				lhs = wide_t'(mid * mid) * s;
				if (lhs <= rhs)
					lo = mid;
				else
					hi = mid - 1;
			end
			q = neg[k] ? -lo : lo;
			comp[k] = q[31:0];
		end
		r.nx = comp[0];
		r.ny = comp[1];
		r.nz = comp[2];
		r.degen = 1'b0;
		return r;
	endfunction

	function automatic tri_t make_tri(coord_t a0, coord_t a1, coord_t a2, coord_t b0,
			coord_t b1, coord_t b2, coord_t e0, coord_t e1, coord_t e2);
		tri_t t;
		t.v = '{a0, a1, a2, b0, b1, b2, e0, e1, e2};
		return t;
	endfunction

	function automatic void add_row(tri_t t, bit typed, normal_t res);
		row_t r;
		r.t = t;
		r.typed = typed;
		r.res = res;
		table_rows.push_back(r);
	endfunction

	function automatic coord_t rand_coord(int span);
		if (span == 0)
			return coord_t'($urandom);
		return coord_t'($urandom_range(0, 2 * span) - span);
	endfunction

	// Random triangle: mostly general position, some small, some degenerate.
	function automatic tri_t rand_tri();
		tri_t t;
		int   kind;
		int   span;
		int   m;
		kind = $urandom_range(0, 9);
		span = (kind < 5) ? 0 : (kind < 8) ? $urandom_range(1, 1000) : 0;
		for (int i = 0; i < 9; i++)
			t.v[i] = rand_coord(span);
		if (kind == 8) begin
			// Two vertices coincide.
			for (int i = 0; i < 3; i++)
				t.v[6 + i] = t.v[3 + i];
		end else if (kind == 9) begin
			// Collinear points: p2 = p1 + m * (p1 - p0) with small coordinates.
			m = $urandom_range(0, 6) - 3;
			for (int i = 0; i < 6; i++)
				t.v[i] = rand_coord(10000);
			for (int i = 0; i < 3; i++)
				t.v[6 + i] = t.v[3 + i] + coord_t'(m) * (t.v[3 + i] - t.v[i]);
		end
		return t;
	endfunction

	// Present one item from the falling edge and hold it until accepted.
	task automatic send_item(tri_t t);
		int gap;
		gap = $urandom_range(0, 8);
		if ($urandom_range(0, 3) == 0)
			gap = 0;
		if (gap > 0) begin
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
		{p0_x, p0_y, p0_z} = {t.v[0], t.v[1], t.v[2]};
		{p1_x, p1_y, p1_z} = {t.v[3], t.v[4], t.v[5]};
		{p2_x, p2_y, p2_z} = {t.v[6], t.v[7], t.v[8]};
		start = 1'b1;
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	// Record the expected normal of each accepted item and check each result.
	always @(posedge clk) begin
		normal_t e;
		tri_t    t;
		if (done) begin
			if (pending_normals.size() == 0) begin
				$error("result with no item outstanding");
				errors++;
			end else begin
				e = pending_normals.pop_front();
				if (normal_x !== e.nx) begin
					$error("normal_x expected %0d actual %0d", e.nx, normal_x);
					errors++;
				end
				if (normal_y !== e.ny) begin
					$error("normal_y expected %0d actual %0d", e.ny, normal_y);
					errors++;
				end
				if (normal_z !== e.nz) begin
					$error("normal_z expected %0d actual %0d", e.nz, normal_z);
					errors++;
				end
				if (degenerate !== e.degen) begin
					$error("degenerate expected %0d actual %0d", e.degen, degenerate);
					errors++;
				end
			end
		end
		if (arst_n && start && !busy) begin
			t = make_tri(p0_x, p0_y, p0_z, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z);
			pending_normals.push_back(unit_normal(t));
		end
	end

	// Watchdog for a hung pipeline.
	initial begin
		#5000000;
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		normal_t none;
		tri_t    t;
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		errors = 0;
		{p0_x, p0_y, p0_z, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z} = '0;
		none = '{'0, '0, '0, 1'b0};

		// Directed rows; expectations are typed in where they are obvious.
		add_row(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0), 1, '{'0, '0, '0, 1'b1});
		add_row(make_tri(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX), 1,
			'{'0, '0, '0, 1'b1});
		add_row(make_tri(CMIN, CMIN, CMIN, 0, 0, 0, CMAX, CMAX, CMAX), 0, none);
		add_row(make_tri(0, 0, 0, 1, 0, 0, 1, 1, 0), 1, '{'0, '0, ONE, 1'b0});
		add_row(make_tri(0, 0, 0, 1, 0, 0, 1, -1, 0), 1, '{'0, '0, -ONE, 1'b0});
		add_row(make_tri(0, 0, 0, 0, 1, 0, 0, 1, 1), 1, '{ONE, '0, '0, 1'b0});
		add_row(make_tri(0, 0, 0, 0, 0, 1, 1, 0, 1), 1, '{'0, ONE, '0, 1'b0});
		add_row(make_tri(CMAX, 0, 0, CMIN, 0, 0, CMIN, CMAX, 0), 1, '{'0, '0, -ONE, 1'b0});
		add_row(make_tri(CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMAX, CMIN), 0, none);
		add_row(make_tri(CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMIN, CMAX), 0, none);
		add_row(make_tri(CMAX, CMIN, 0, CMIN, CMAX, CMIN, 0, CMIN, CMAX), 0, none);
		add_row(make_tri(1, 2, 3, 4, 5, 6, 7, 8, 10), 0, none);
		add_row(make_tri(0, 0, 0, 1, 1, 1, 2, 3, 5), 0, none);
		add_row(make_tri(-1, -1, -1, 0, 0, 0, 1, 1, 1), 1, '{'0, '0, '0, 1'b1});
		add_row(make_tri(5, 0, 0, 0, 5, 0, 0, 0, 5), 0, none);

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (table_rows[i]) begin
			if (table_rows[i].typed && unit_normal(table_rows[i].t) != table_rows[i].res) begin
				$error("directed row %0d disagrees with the predictor", i);
				errors++;
			end
			send_item(table_rows[i].t);
		end

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			// Drain the pipeline completely at a few points along the way.
			if (n % 500 == 250) begin
				start = 1'b0;
				wait (pending_normals.size() == 0);
				@(negedge clk);
			end
			t = rand_tri();
			send_item(t);
		end
		start = 1'b0;

		wait (pending_normals.size() == 0);
		repeat (LATENCY + 10) @(posedge clk);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
